// File: src/vertex_affine_transform_2d_top_macros.svh
// ----------------------------------------------------------------------------
// vertex_affine_transform_2d_top_macros
// Assertion macros for the 2-D vertex transform; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef VERTEX_AFFINE_TRANSFORM_2D_TOP_MACROS_SVH
`define VERTEX_AFFINE_TRANSFORM_2D_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define VAT2D_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vat2d: same-cycle check failed");

`define VAT2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vat2d: next-cycle check failed");

`else

`define VAT2D_ASSERT_SAME(lbl, ante, cons)
`define VAT2D_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/vat2d_pkg.sv
// ----------------------------------------------------------------------------
// vat2d_pkg
// Types and constants shared by the 2-D vertex transform datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vat2d_pkg;

    localparam int COORD_W = 16;
    localparam int COEF_W  = 16;
    localparam int DELTA_W = COORD_W + 1;
    localparam int BASE_W  = COORD_W + 2;
    localparam int PROD_W  = DELTA_W + COEF_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int OUT_W   = 25;
    localparam int OP_W    = 4;
    localparam int CFG_W   = 3;

    localparam int FRAC_BITS_Q8  = 8;
    localparam int FRAC_BITS_Q14 = 14;

    localparam logic signed [ACC_W-1:0] HALF_Q8  = ACC_W'(1 << (FRAC_BITS_Q8 - 1));
    localparam logic signed [ACC_W-1:0] HALF_Q14 = ACC_W'(1 << (FRAC_BITS_Q14 - 1));

    localparam logic signed [COEF_W-1:0] COS_RESET   = COEF_W'(1 << FRAC_BITS_Q14);
    localparam logic signed [COEF_W-1:0] SCALE_RESET = COEF_W'(1 << FRAC_BITS_Q8);

    typedef enum logic [OP_W-1:0] {
        OP_TRANSLATE     = 4'd0,
        OP_SCALE_ORIGIN  = 4'd1,
        OP_SCALE_PIVOT   = 4'd2,
        OP_ROTATE_ORIGIN = 4'd3,
        OP_ROTATE_PIVOT  = 4'd4,
        OP_REFLECT_X     = 4'd5,
        OP_REFLECT_Y     = 4'd6,
        OP_REFLECT_O     = 4'd7,
        OP_REFLECT_DIAG  = 4'd8,
        OP_SHEAR_X       = 4'd9,
        OP_SHEAR_Y       = 4'd10
    } t_op;

    typedef enum logic [CFG_W-1:0] {
        CFG_SHIFT_X   = 3'd0,
        CFG_SHIFT_Y   = 3'd1,
        CFG_COS_ANGLE = 3'd2,
        CFG_SIN_ANGLE = 3'd3,
        CFG_SCALE_X   = 3'd4,
        CFG_SCALE_Y   = 3'd5,
        CFG_SHEAR_X   = 3'd6,
        CFG_SHEAR_Y   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FRAC_INT = 2'd0,
        FRAC_Q8  = 2'd1,
        FRAC_Q14 = 2'd2
    } t_frac;

    typedef struct packed {
        logic signed [DELTA_W-1:0] opnd0;
        logic signed [COEF_W-1:0]  coef0;
        logic signed [DELTA_W-1:0] opnd1;
        logic signed [COEF_W-1:0]  coef1;
        logic signed [BASE_W-1:0]  base;
        t_frac                     frac;
    } t_lane_op;

endpackage

`default_nettype wire

// File: src/vertex_affine_transform_2d_top.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform_2d_top
// 2-D affine transform of one integer vertex per beat.
//
// Input channel (i_in_valid / o_in_ready) carries an operation code, the
// vertex and an optional pivot. Output channel (o_out_valid / i_out_ready)
// carries the transformed vertex, rounded half away from zero.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes one of eight
// 16-bit registers per beat; it is always ready. Write only while idle.
//
// Pipeline: input register, product register, result register, with the two
// 17x16 multipliers per coordinate in the product stage. Throughput: one
// vertex per cycle while the receiver accepts.
// Each stage advances when its successor is empty or advancing, so a
// stalled receiver fills the pipe; up to three beats are held before
// o_in_ready drops. Reset empties the pipe and restores identity settings.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_affine_transform_2d_top_macros.svh"

module vertex_affine_transform_2d_top
    import vat2d_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_W-1:0]          i_cfg_index,
    input  wire logic [COEF_W-1:0]         i_cfg_data,

    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [OP_W-1:0]           i_operation,
    input  wire logic signed [COORD_W-1:0] i_vert_x,
    input  wire logic signed [COORD_W-1:0] i_vert_y,
    input  wire logic signed [COORD_W-1:0] i_pivot_x,
    input  wire logic signed [COORD_W-1:0] i_pivot_y,

    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [OUT_W-1:0]        o_out_x,
    output logic signed [OUT_W-1:0]        o_out_y
);

    logic signed [COEF_W-1:0] r_shift_x;
    logic signed [COEF_W-1:0] r_shift_y;
    logic signed [COEF_W-1:0] r_cos;
    logic signed [COEF_W-1:0] r_sin;
    logic signed [COEF_W-1:0] r_scale_x;
    logic signed [COEF_W-1:0] r_scale_y;
    logic signed [COEF_W-1:0] r_shear_x;
    logic signed [COEF_W-1:0] r_shear_y;

    logic                      r_a_vld;
    logic [OP_W-1:0]           r_operation;
    logic signed [COORD_W-1:0] r_vert_x;
    logic signed [COORD_W-1:0] r_vert_y;
    logic signed [COORD_W-1:0] r_pivot_x;
    logic signed [COORD_W-1:0] r_pivot_y;

    logic                      r_b_vld;
    logic                      r_out_vld;
    logic signed [OUT_W-1:0]   r_out_x;
    logic signed [OUT_W-1:0]   r_out_y;

    logic                      w_ld_a;
    logic                      w_ld_b;
    logic                      w_ld_c;

    logic                      w_pivot_mode;
    logic signed [COORD_W-1:0] w_px;
    logic signed [COORD_W-1:0] w_py;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic signed [DELTA_W-1:0] w_ndy;
    logic signed [DELTA_W-1:0] w_x17;
    logic signed [DELTA_W-1:0] w_y17;
    logic signed [BASE_W-1:0]  w_x18;
    logic signed [BASE_W-1:0]  w_y18;
    logic signed [BASE_W-1:0]  w_px18;
    logic signed [BASE_W-1:0]  w_py18;

    t_lane_op                  w_op_x;
    t_lane_op                  w_op_y;
    logic signed [OUT_W-1:0]   w_res_x;
    logic signed [OUT_W-1:0]   w_res_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_cos     <= COS_RESET;
            r_sin     <= '0;
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
            r_shear_x <= '0;
            r_shear_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SHIFT_X:   r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y:   r_shift_y <= i_cfg_data;
                CFG_COS_ANGLE: r_cos     <= i_cfg_data;
                CFG_SIN_ANGLE: r_sin     <= i_cfg_data;
                CFG_SCALE_X:   r_scale_x <= i_cfg_data;
                CFG_SCALE_Y:   r_scale_y <= i_cfg_data;
                CFG_SHEAR_X:   r_shear_x <= i_cfg_data;
                CFG_SHEAR_Y:   r_shear_y <= i_cfg_data;
            endcase
        end
    end

    assign w_ld_c     = !r_out_vld || i_out_ready;
    assign w_ld_b     = !r_b_vld || w_ld_c;
    assign w_ld_a     = !r_a_vld || w_ld_b;
    assign o_in_ready = w_ld_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_ld_a) begin
                r_a_vld <= i_in_valid;
            end
            if (w_ld_b) begin
                r_b_vld <= r_a_vld;
            end
            if (w_ld_c) begin
                r_out_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a && i_in_valid) begin
            r_operation <= i_operation;
            r_vert_x    <= i_vert_x;
            r_vert_y    <= i_vert_y;
            r_pivot_x   <= i_pivot_x;
            r_pivot_y   <= i_pivot_y;
        end
        if (w_ld_c && r_b_vld) begin
            r_out_x <= w_res_x;
            r_out_y <= w_res_y;
        end
    end

    assign w_pivot_mode = (t_op'(r_operation) == OP_SCALE_PIVOT)
                       || (t_op'(r_operation) == OP_ROTATE_PIVOT);
    assign w_px   = w_pivot_mode ? r_pivot_x : '0;
    assign w_py   = w_pivot_mode ? r_pivot_y : '0;
    assign w_x17  = DELTA_W'(r_vert_x);
    assign w_y17  = DELTA_W'(r_vert_y);
    assign w_dx   = w_x17 - DELTA_W'(w_px);
    assign w_dy   = w_y17 - DELTA_W'(w_py);
    assign w_ndy  = DELTA_W'(w_py) - w_y17;
    assign w_x18  = BASE_W'(r_vert_x);
    assign w_y18  = BASE_W'(r_vert_y);
    assign w_px18 = BASE_W'(w_px);
    assign w_py18 = BASE_W'(w_py);

    always_comb begin
        w_op_x = '{opnd0: '0, coef0: '0, opnd1: '0, coef1: '0,
                   base: w_x18, frac: FRAC_INT};
        w_op_y = '{opnd0: '0, coef0: '0, opnd1: '0, coef1: '0,
                   base: w_y18, frac: FRAC_INT};
        unique case (t_op'(r_operation))
            OP_TRANSLATE: begin
                w_op_x.base = w_x18 + BASE_W'(r_shift_x);
                w_op_y.base = w_y18 + BASE_W'(r_shift_y);
            end
            OP_SCALE_ORIGIN, OP_SCALE_PIVOT: begin
                w_op_x = '{opnd0: w_dx, coef0: r_scale_x, opnd1: '0, coef1: '0,
                           base: w_px18, frac: FRAC_Q8};
                w_op_y = '{opnd0: w_dy, coef0: r_scale_y, opnd1: '0, coef1: '0,
                           base: w_py18, frac: FRAC_Q8};
            end
            OP_ROTATE_ORIGIN, OP_ROTATE_PIVOT: begin
                w_op_x = '{opnd0: w_dx, coef0: r_cos, opnd1: w_ndy, coef1: r_sin,
                           base: w_px18, frac: FRAC_Q14};
                w_op_y = '{opnd0: w_dx, coef0: r_sin, opnd1: w_dy, coef1: r_cos,
                           base: w_py18, frac: FRAC_Q14};
            end
            OP_REFLECT_X: begin
                w_op_y.base = -w_y18;
            end
            OP_REFLECT_Y: begin
                w_op_x.base = -w_x18;
            end
            OP_REFLECT_O: begin
                w_op_x.base = -w_x18;
                w_op_y.base = -w_y18;
            end
            OP_REFLECT_DIAG: begin
                w_op_x.base = w_y18;
                w_op_y.base = w_x18;
            end
            OP_SHEAR_X: begin
                w_op_x = '{opnd0: w_y17, coef0: r_shear_x, opnd1: '0, coef1: '0,
                           base: w_x18, frac: FRAC_Q8};
            end
            OP_SHEAR_Y: begin
                w_op_y = '{opnd0: w_x17, coef0: r_shear_y, opnd1: '0, coef1: '0,
                           base: w_y18, frac: FRAC_Q8};
            end
            default: begin
            end
        endcase
    end

    vat2d_lane u_lane_x (
        .i_clk (i_clk),
        .i_ld  (w_ld_b && r_a_vld),
        .i_op  (w_op_x),
        .o_res (w_res_x)
    );

    vat2d_lane u_lane_y (
        .i_clk (i_clk),
        .i_ld  (w_ld_b && r_a_vld),
        .i_op  (w_op_y),
        .o_res (w_res_y)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;

    `VAT2D_ASSERT_NEXT(a_prod_stage_fill, r_a_vld && w_ld_b, r_b_vld)
    `VAT2D_ASSERT_NEXT(a_out_stage_fill, r_b_vld && w_ld_c, r_out_vld)
    `VAT2D_ASSERT_SAME(a_full_pipe_blocks, r_out_vld && !i_out_ready && r_b_vld && r_a_vld, !o_in_ready)
    `VAT2D_ASSERT_NEXT(a_cos_write, i_cfg_valid && (i_cfg_index == CFG_COS_ANGLE), r_cos == $past(i_cfg_data))

endmodule

`default_nettype wire

// File: src/vat2d_lane.sv
// ----------------------------------------------------------------------------
// vat2d_lane
// One coordinate: two products and a scaled base registered, then summed and
// rounded half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vat2d_lane
    import vat2d_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_ld,
    input  wire t_lane_op                i_op,
    output logic signed [OUT_W-1:0]      o_res
);

    logic signed [DELTA_W-1:0] w_opnd0;
    logic signed [DELTA_W-1:0] w_opnd1;
    logic signed [COEF_W-1:0]  w_coef0;
    logic signed [COEF_W-1:0]  w_coef1;
    logic signed [BASE_W-1:0]  w_base;

    logic signed [PROD_W-1:0]  n_p0;
    logic signed [PROD_W-1:0]  n_p1;
    logic signed [ACC_W-1:0]   n_bs;
    logic signed [PROD_W-1:0]  r_p0;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [ACC_W-1:0]   r_bs;
    t_frac                     r_frac;

    logic signed [ACC_W-1:0]   w_sum;
    logic signed [ACC_W-1:0]   w_q8;
    logic signed [ACC_W-1:0]   w_q14;
    logic                      w_corr8;
    logic                      w_corr14;

    assign w_opnd0 = i_op.opnd0;
    assign w_opnd1 = i_op.opnd1;
    assign w_coef0 = i_op.coef0;
    assign w_coef1 = i_op.coef1;
    assign w_base  = i_op.base;

    assign n_p0 = w_opnd0 * w_coef0;
    assign n_p1 = w_opnd1 * w_coef1;

    always_comb begin
        unique case (i_op.frac)
            FRAC_Q8:  n_bs = (ACC_W'(w_base) <<< FRAC_BITS_Q8) + HALF_Q8;
            FRAC_Q14: n_bs = (ACC_W'(w_base) <<< FRAC_BITS_Q14) + HALF_Q14;
            default:  n_bs = ACC_W'(w_base);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_bs   <= n_bs;
            r_frac <= i_op.frac;
        end
    end

    assign w_sum = ACC_W'(r_p0) + ACC_W'(r_p1) + r_bs;
    assign w_q8  = w_sum >>> FRAC_BITS_Q8;
    assign w_q14 = w_sum >>> FRAC_BITS_Q14;

    // step a negative exact half back down, away from zero
    assign w_corr8  = (w_sum < HALF_Q8) && (w_sum[FRAC_BITS_Q8-1:0] == '0);
    assign w_corr14 = (w_sum < HALF_Q14) && (w_sum[FRAC_BITS_Q14-1:0] == '0);

    always_comb begin
        unique case (r_frac)
            FRAC_Q8:  o_res = w_q8[OUT_W-1:0] - OUT_W'(w_corr8);
            FRAC_Q14: o_res = w_q14[OUT_W-1:0] - OUT_W'(w_corr14);
            default:  o_res = w_sum[OUT_W-1:0];
        endcase
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_vertex_affine_transform_2d_top.sv
// ----------------------------------------------------------------------------
// tb_vertex_affine_transform_2d_top
// Self-checking bench for the 2-D vertex transform.
//
// A local predictor mirrors the eight transform registers and computes the
// rounded result of every accepted vertex beat. An output monitor compares
// each result beat, field by field, against the oldest pending prediction.
// Directed beats cover reset settings, every opcode with extreme operands
// and out-of-range registers, and rounding of halves; random phases then run
// under several register sets with random gaps on both channels, one phase
// without gaps, and one long receiver hold that backs up the pipe.
// ----------------------------------------------------------------------------
module tb_vertex_affine_transform_2d_top
    import vat2d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VMAX          = 32767;
    localparam int VMIN          = -32768;
    localparam int HOLD_CYCLES   = 48;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS   = 80;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [OUT_W-1:0]  x;
        logic signed [OUT_W-1:0]  y;
    } t_vertex;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_W-1:0]            i_cfg_index = '0;
    logic [COEF_W-1:0]           i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [OP_W-1:0]             i_operation = '0;
    logic signed [COORD_W-1:0]   i_vert_x = '0;
    logic signed [COORD_W-1:0]   i_vert_y = '0;
    logic signed [COORD_W-1:0]   i_pivot_x = '0;
    logic signed [COORD_W-1:0]   i_pivot_y = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [OUT_W-1:0]     o_out_x;
    logic signed [OUT_W-1:0]     o_out_y;

    logic signed [COEF_W-1:0]    xf_reg [8];
    t_vertex                     pending_vertices [$];
    int                          mismatch_count = 0;
    int                          idle_cycles = 0;
    bit                          steady = 1'b0;
    int unsigned                 hold_gen = 0;
    int unsigned                 hold_ack = 0;
    int                          hold_left = 0;

    vertex_affine_transform_2d_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_vert_x    (i_vert_x),
        .i_vert_y    (i_vert_y),
        .i_pivot_x   (i_pivot_x),
        .i_pivot_y   (i_pivot_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint round_half_away(input longint num, input int frac);
        longint half;
        half = longint'(1) << (frac - 1);
        if (num >= 0)
            return (num + half) >>> frac;
        return -((-num + half) >>> frac);
    endfunction

    function automatic t_vertex transform_vertex(
        input logic [OP_W-1:0]         op,
        input logic signed [COORD_W-1:0] vx,
        input logic signed [COORD_W-1:0] vy,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py
    );
        longint x, y, qx, qy, tx, ty, c, s, kx, ky, one8, one14;
        t_vertex v;
        x = longint'(vx);
        y = longint'(vy);
        qx = longint'(px);
        qy = longint'(py);
        c = longint'(xf_reg[CFG_COS_ANGLE]);
        s = longint'(xf_reg[CFG_SIN_ANGLE]);
        kx = longint'(xf_reg[CFG_SCALE_X]);
        ky = longint'(xf_reg[CFG_SCALE_Y]);
        one8 = longint'(1) << FRAC_BITS_Q8;
        one14 = longint'(1) << FRAC_BITS_Q14;
        tx = x;
        ty = y;
        case (op)
            OP_TRANSLATE: begin
                tx = x + longint'(xf_reg[CFG_SHIFT_X]);
                ty = y + longint'(xf_reg[CFG_SHIFT_Y]);
            end
            OP_SCALE_ORIGIN: begin
                tx = round_half_away(x * kx, FRAC_BITS_Q8);
                ty = round_half_away(y * ky, FRAC_BITS_Q8);
            end
            OP_SCALE_PIVOT: begin
                tx = round_half_away(x * kx + qx * (one8 - kx), FRAC_BITS_Q8);
                ty = round_half_away(y * ky + qy * (one8 - ky), FRAC_BITS_Q8);
            end
            OP_ROTATE_ORIGIN: begin
                tx = round_half_away(x * c - y * s, FRAC_BITS_Q14);
                ty = round_half_away(x * s + y * c, FRAC_BITS_Q14);
            end
            OP_ROTATE_PIVOT: begin
                tx = round_half_away(x * c - y * s + qx * (one14 - c) + qy * s,
                                     FRAC_BITS_Q14);
                ty = round_half_away(x * s + y * c + qy * (one14 - c) - qx * s,
                                     FRAC_BITS_Q14);
            end
            OP_REFLECT_X: ty = -y;
            OP_REFLECT_Y: tx = -x;
            OP_REFLECT_O: begin
                tx = -x;
                ty = -y;
            end
            OP_REFLECT_DIAG: begin
                tx = y;
                ty = x;
            end
            OP_SHEAR_X:
                tx = round_half_away(x * one8 + longint'(xf_reg[CFG_SHEAR_X]) * y,
                                     FRAC_BITS_Q8);
            OP_SHEAR_Y:
                ty = round_half_away(y * one8 + longint'(xf_reg[CFG_SHEAR_Y]) * x,
                                     FRAC_BITS_Q8);
            default: ;
        endcase
        v.op = op;
        v.x = OUT_W'(tx);
        v.y = OUT_W'(ty);
        return v;
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_result();
        t_vertex want;
        if (pending_vertices.size() == 0) begin
            log_mismatch($sformatf("unexpected beat x=%0d y=%0d", o_out_x, o_out_y));
            return;
        end
        want = pending_vertices.pop_front();
        if (o_out_x !== want.x)
            log_mismatch($sformatf("op %0d out_x got %0d want %0d", want.op, o_out_x, want.x));
        if (o_out_y !== want.y)
            log_mismatch($sformatf("op %0d out_y got %0d want %0d", want.op, o_out_y, want.y));
    endtask

    // output monitor and receiver ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_result();
        if (hold_gen != hold_ack) begin
            hold_ack <= hold_gen;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_vertex(
        input logic [OP_W-1:0]         op,
        input logic signed [COORD_W-1:0] vx,
        input logic signed [COORD_W-1:0] vy,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py
    );
        t_vertex expect_v;
        while (!steady && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_vert_x <= vx;
        i_vert_y <= vy;
        i_pivot_x <= px;
        i_pivot_y <= py;
        do @(posedge i_clk); while (!o_in_ready);
        expect_v = transform_vertex(op, vx, vy, px, py);
        pending_vertices.insert(pending_vertices.size(), expect_v);
    endtask

    // drain the pipe, then program all eight registers back to back
    task automatic write_settings(
        input int shift_x,
        input int shift_y,
        input int cos_a,
        input int sin_a,
        input int scale_x,
        input int scale_y,
        input int shear_x,
        input int shear_y
    );
        logic signed [COEF_W-1:0] vals [8];
        vals[CFG_SHIFT_X] = COEF_W'(shift_x);
        vals[CFG_SHIFT_Y] = COEF_W'(shift_y);
        vals[CFG_COS_ANGLE] = COEF_W'(cos_a);
        vals[CFG_SIN_ANGLE] = COEF_W'(sin_a);
        vals[CFG_SCALE_X] = COEF_W'(scale_x);
        vals[CFG_SCALE_Y] = COEF_W'(scale_y);
        vals[CFG_SHEAR_X] = COEF_W'(shear_x);
        vals[CFG_SHEAR_Y] = COEF_W'(shear_y);
        i_in_valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge i_clk);
        for (int i = 0; i < $size(vals); i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_W'(i);
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            xf_reg[i] = vals[i];
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(15))
            0: return COORD_W'(VMIN);
            1: return COORD_W'(VMAX);
            2: return '0;
            3: return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic int pick_coef(input bit angle);
        case ($urandom_range(7))
            0: return VMIN;
            1: return VMAX;
            2: return 0;
            3: return int'($urandom_range(1024)) - 512;
            default:
                if (angle)
                    return int'($urandom_range(32768)) - 16384;
                else
                    return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        if ($urandom_range(99) < 12)
            return OP_W'($urandom_range(11, 15));
        return OP_W'($urandom_range(OP_SHEAR_Y));
    endfunction

    task automatic test_reset_settings();
        send_vertex(OP_SCALE_ORIGIN, 16'sd1234, -16'sd4321, '0, '0);
        send_vertex(OP_ROTATE_ORIGIN, COORD_W'(VMIN), COORD_W'(VMAX), '0, '0);
        send_vertex(OP_TRANSLATE, COORD_W'(VMAX), COORD_W'(VMIN), '0, '0);
    endtask

    // every opcode, unused ones too, with cos and sin at the ends of their Q2.14 range, beyond +/-1.0
    task automatic test_extreme_ops();
        write_settings(VMAX, VMIN, VMIN, VMAX, VMIN, VMAX, VMAX, VMIN);
        for (int k = 0; k < (1 << OP_W); k++)
            send_vertex(OP_W'(k), COORD_W'(VMIN), COORD_W'(VMAX),
                        COORD_W'(VMAX), COORD_W'(VMIN));
        send_vertex(OP_SCALE_PIVOT, COORD_W'(VMAX), COORD_W'(VMIN),
                    COORD_W'(VMIN), COORD_W'(VMAX));
        send_vertex(OP_ROTATE_PIVOT, COORD_W'(VMAX), COORD_W'(VMIN),
                    COORD_W'(VMIN), COORD_W'(VMAX));
    endtask

    // exact halves on both signs
    task automatic test_rounding();
        write_settings(0, 0, 8192, -8192, 128, -128, 128, -384);
        send_vertex(OP_SCALE_ORIGIN, 16'sd1, -16'sd1, '0, '0);
        send_vertex(OP_SHEAR_X, 16'sd0, -16'sd1, '0, '0);
        send_vertex(OP_SHEAR_Y, 16'sd1, 16'sd0, '0, '0);
        send_vertex(OP_ROTATE_ORIGIN, 16'sd1, 16'sd0, '0, '0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0)
                write_settings(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
            else if (phase == 1)
                write_settings(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN);
            else
                write_settings(pick_coef(1'b0), pick_coef(1'b0),
                               pick_coef(1'b1), pick_coef(1'b1),
                               pick_coef(1'b0), pick_coef(1'b0),
                               pick_coef(1'b0), pick_coef(1'b0));
            steady <= (phase == 2);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (phase == 3 && n == 20)
                    hold_gen <= hold_gen + 1;
                send_vertex(pick_op(), pick_coord(), pick_coord(),
                            pick_coord(), pick_coord());
            end
        end
        steady <= 1'b0;
    endtask

    initial begin
        xf_reg[CFG_SHIFT_X] = '0;
        xf_reg[CFG_SHIFT_Y] = '0;
        xf_reg[CFG_COS_ANGLE] = COS_RESET;
        xf_reg[CFG_SIN_ANGLE] = '0;
        xf_reg[CFG_SCALE_X] = SCALE_RESET;
        xf_reg[CFG_SCALE_Y] = SCALE_RESET;
        xf_reg[CFG_SHEAR_X] = '0;
        xf_reg[CFG_SHEAR_Y] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_extreme_ops();
        test_rounding();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
